/* sv/laws_texture_convolution_5x5_macros.svh */
// ============================================================================
// Laws texture convolution assertion macros
// Shared property forms for the checker of the 5x5 Laws filter.
// ============================================================================
`ifndef LAWS_TEXTURE_CONVOLUTION_5X5_MACROS_SVH
`define LAWS_TEXTURE_CONVOLUTION_5X5_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define L5_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define L5_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/laws5_pkg.sv */
// ============================================================================
// Laws 5x5 filter package
// Shared widths, register codes, item types and the Laws vector taps.
// ============================================================================
`timescale 1ns / 1ps

package laws5_pkg;

    localparam int MASK_SIZE   = 5;
    localparam int MASK_HALF   = MASK_SIZE / 2;
    localparam int LB_ROWS     = MASK_SIZE - 1;
    localparam int PIX_W       = 8;
    localparam int SEL_W       = 3;
    localparam int DIM_W       = 11;
    localparam int POS_W       = 10;
    localparam int FV_W        = 17;
    localparam int TAP_W       = 4;
    localparam int COEF_W      = 7;
    localparam int PROD_W      = 16;
    localparam int MAX_HEIGHT  = 1024;
    localparam int CFG_IDX_W   = 2;
    localparam int QUEUE_DEPTH = 4;
    localparam int QP_W        = $clog2(QUEUE_DEPTH);
    localparam int QLVL_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_SEL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COL_SEL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT  = 2'd3;

    // Laws vector codes.
    localparam logic [SEL_W-1:0] SEL_L5 = 3'd0;
    localparam logic [SEL_W-1:0] SEL_E5 = 3'd1;
    localparam logic [SEL_W-1:0] SEL_S5 = 3'd2;
    localparam logic [SEL_W-1:0] SEL_R5 = 3'd3;
    localparam logic [SEL_W-1:0] SEL_W5 = 3'd4;

    localparam logic [DIM_W-1:0] DIM_RESET = 11'd1024;

    typedef logic [PIX_W-1:0]          pix_t;
    typedef logic signed [TAP_W-1:0]   tap_t;
    typedef logic signed [COEF_W-1:0]  coef_t;
    typedef pix_t [MASK_SIZE-1:0][MASK_SIZE-1:0] win_t;

    typedef struct packed {
        logic [SEL_W-1:0] row_sel;
        logic [SEL_W-1:0] col_sel;
        logic [DIM_W-1:0] image_width;
        logic [DIM_W-1:0] image_height;
    } cfg_t;

    typedef struct packed {
        logic [POS_W-1:0] centre_row;
        logic [POS_W-1:0] centre_col;
        logic             frame_last;
    } meta_t;

    typedef struct packed {
        win_t  win;
        meta_t meta;
    } item_t;

    typedef struct packed {
        logic              empty;
        logic [QLVL_W-1:0] level;
    } q_stat_t;

    // Tap idx of the selected Laws vector; codes above W5 saturate to W5.
    function automatic tap_t laws_tap(input logic [SEL_W-1:0] sel, input int unsigned idx);
        logic [MASK_SIZE*TAP_W-1:0] vec;
        begin
            unique case (sel)
                SEL_L5:  vec = {4'sd1, 4'sd4, 4'sd6, 4'sd4, 4'sd1};
                SEL_E5:  vec = {4'sd1, 4'sd2, 4'sd0, -4'sd2, -4'sd1};
                SEL_S5:  vec = {-4'sd1, 4'sd0, 4'sd2, 4'sd0, -4'sd1};
                SEL_R5:  vec = {4'sd1, -4'sd4, 4'sd6, -4'sd4, 4'sd1};
                default: vec = {4'sd1, -4'sd2, 4'sd0, 4'sd2, -4'sd1};
            endcase
            return tap_t'(vec[idx*TAP_W +: TAP_W]);
        end
    endfunction

endpackage

/* sv/laws5_front.sv */
// ============================================================================
// Laws 5x5 front end
// Raster counters, line buffer memory and the 5x5 window; forwards each
// window that lies fully inside the image to the queue.
// ============================================================================
`timescale 1ns / 1ps

module laws5_front import laws5_pkg::*; #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  pix_t       s_pixel,
    input  cfg_t       cfg,
    input  q_stat_t    q_stat,
    output logic       push,
    output item_t      push_item
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int CW = (WW > DIM_W) ? WW : DIM_W;
    localparam int LW = QLVL_W + 1;

    logic [LB_ROWS*PIX_W-1:0] lbuf_mem [MAX_WIDTH];
    logic [LB_ROWS*PIX_W-1:0] lbuf_rd_reg;
    logic [LB_ROWS*PIX_W-1:0] lbuf_wr_data;

    logic [AW-1:0]    col_cnt_reg, col_cnt_next;
    logic [POS_W-1:0] row_cnt_reg, row_cnt_next;
    logic [CW-1:0]    col_ext, w_in, eff_w;
    logic [DIM_W-1:0] row_ext, eff_h;
    logic [LW-1:0]    in_flight;
    logic             accept;
    logic             emit_now;
    meta_t            meta_now;

    logic             p1_valid_reg, p1_emit_reg, p2_valid_reg;
    pix_t             p1_pix_reg;
    logic [AW-1:0]    p1_addr_reg;
    meta_t            p1_meta_reg, p2_meta_reg;
    pix_t [MASK_SIZE-1:0] new_col;
    win_t             win_reg, win_next;

    // Reserve a queue slot for every pixel still in the two front stages.
    assign in_flight = LW'(q_stat.level) + LW'(p1_valid_reg) + LW'(p2_valid_reg);
    assign s_ready   = (in_flight < LW'(QUEUE_DEPTH));
    assign accept    = s_valid && s_ready;

    always_comb begin
        col_ext = CW'(col_cnt_reg);
        row_ext = DIM_W'(row_cnt_reg);
        w_in    = CW'(cfg.image_width);
        if (w_in < CW'(MASK_SIZE)) begin
            eff_w = CW'(MASK_SIZE);
        end else if (w_in > CW'(MAX_WIDTH)) begin
            eff_w = CW'(MAX_WIDTH);
        end else begin
            eff_w = w_in;
        end
        if (cfg.image_height < DIM_W'(MASK_SIZE)) begin
            eff_h = DIM_W'(MASK_SIZE);
        end else if (cfg.image_height > DIM_W'(MAX_HEIGHT)) begin
            eff_h = DIM_W'(MAX_HEIGHT);
        end else begin
            eff_h = cfg.image_height;
        end
    end

    always_comb begin
        emit_now = (row_cnt_reg >= POS_W'(LB_ROWS)) && (col_ext >= CW'(LB_ROWS));
        meta_now.centre_row = row_cnt_reg - POS_W'(MASK_HALF);
        meta_now.centre_col = POS_W'(col_ext - CW'(MASK_HALF));
        meta_now.frame_last = (row_ext == eff_h - DIM_W'(1)) && (col_ext == eff_w - CW'(1));
        row_cnt_next = row_cnt_reg;
        if (col_ext + CW'(1) >= eff_w) begin
            col_cnt_next = '0;
            if (row_ext + DIM_W'(1) >= eff_h) begin
                row_cnt_next = '0;
            end else begin
                row_cnt_next = row_cnt_reg + POS_W'(1);
            end
        end else begin
            col_cnt_next = col_cnt_reg + AW'(1);
        end
    end

    // The column read last cycle feeds the window; rows move up one line.
    always_comb begin
        for (int k = 0; k < LB_ROWS; k++) begin
            new_col[k] = lbuf_rd_reg[k*PIX_W +: PIX_W];
        end
        new_col[LB_ROWS] = p1_pix_reg;
        for (int k = 0; k < LB_ROWS - 1; k++) begin
            lbuf_wr_data[k*PIX_W +: PIX_W] = lbuf_rd_reg[(k+1)*PIX_W +: PIX_W];
        end
        lbuf_wr_data[(LB_ROWS-1)*PIX_W +: PIX_W] = p1_pix_reg;
        for (int k = 0; k < MASK_SIZE; k++) begin
            for (int l = 0; l < MASK_SIZE - 1; l++) begin
                win_next[k][l] = win_reg[k][l+1];
            end
            win_next[k][MASK_SIZE-1] = new_col[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            lbuf_rd_reg <= lbuf_mem[col_cnt_reg];
        end
        if (p1_valid_reg) begin
            lbuf_mem[p1_addr_reg] <= lbuf_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            p1_pix_reg  <= s_pixel;
            p1_addr_reg <= col_cnt_reg;
            p1_meta_reg <= meta_now;
            p1_emit_reg <= emit_now;
        end
        if (p1_valid_reg) begin
            win_reg     <= win_next;
            p2_meta_reg <= p1_meta_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_cnt_reg  <= '0;
            row_cnt_reg  <= '0;
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
        end else begin
            p1_valid_reg <= accept;
            p2_valid_reg <= p1_valid_reg && p1_emit_reg;
            if (accept) begin
                col_cnt_reg <= col_cnt_next;
                row_cnt_reg <= row_cnt_next;
            end
        end
    end

    assign push           = p2_valid_reg;
    assign push_item.win  = win_reg;
    assign push_item.meta = p2_meta_reg;

endmodule

/* sv/laws5_queue.sv */
// ============================================================================
// Laws 5x5 window queue
// Short FIFO of complete windows between the front end and the MAC back end.
// ============================================================================
`timescale 1ns / 1ps

module laws5_queue import laws5_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  item_t   push_item,
    input  logic    pop,
    output item_t   head,
    output q_stat_t q_stat
);

    item_t             q_mem [QUEUE_DEPTH];
    logic [QP_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QLVL_W-1:0] level_reg;

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QP_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QP_W'(1);
            end
            unique case ({push, pop})
                2'b10:   level_reg <= level_reg + QLVL_W'(1);
                2'b01:   level_reg <= level_reg - QLVL_W'(1);
                default: level_reg <= level_reg;
            endcase
        end
    end

    assign head         = q_mem[rd_ptr_reg];
    assign q_stat.empty = (level_reg == '0);
    assign q_stat.level = level_reg;

endmodule

/* sv/laws5_back.sv */
// ============================================================================
// Laws 5x5 back end
// Mask coefficients, 25 parallel products, row sums, total and output register.
// ============================================================================
`timescale 1ns / 1ps

module laws5_back import laws5_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  cfg_t                    cfg,
    input  q_stat_t                 q_stat,
    input  item_t                   head,
    output logic                    pop,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [FV_W-1:0]  m_filtered_value,
    output logic [POS_W-1:0]        m_centre_row,
    output logic [POS_W-1:0]        m_centre_col,
    output logic                    m_frame_last
);

    coef_t                   coef_reg  [MASK_SIZE][MASK_SIZE];
    coef_t                   coef_next [MASK_SIZE][MASK_SIZE];
    logic signed [PROD_W-1:0] prod_reg  [MASK_SIZE][MASK_SIZE];
    logic signed [PROD_W-1:0] prod_next [MASK_SIZE][MASK_SIZE];
    logic signed [FV_W-1:0]  row_sum_reg  [MASK_SIZE];
    logic signed [FV_W-1:0]  row_sum_next [MASK_SIZE];
    logic signed [FV_W-1:0]  total_next;
    logic signed [FV_W-1:0]  fv_reg;
    meta_t                   b1_meta_reg, b2_meta_reg, out_meta_reg;
    logic                    b1_valid_reg, b2_valid_reg, m_valid_reg;
    logic                    adv;

    // The whole back end moves when the output register is free or drained.
    assign adv = !m_valid_reg || m_ready;
    assign pop = adv && !q_stat.empty;

    // Mask rotated by 180 degrees: window pixel (k,l) takes taps 4-k and 4-l.
    always_comb begin
        for (int k = 0; k < MASK_SIZE; k++) begin
            for (int l = 0; l < MASK_SIZE; l++) begin
                coef_next[k][l] = COEF_W'(laws_tap(cfg.row_sel, MASK_SIZE - 1 - k))
                                * COEF_W'(laws_tap(cfg.col_sel, MASK_SIZE - 1 - l));
            end
        end
    end

    always_comb begin
        for (int k = 0; k < MASK_SIZE; k++) begin
            for (int l = 0; l < MASK_SIZE; l++) begin
                prod_next[k][l] = PROD_W'(signed'({1'b0, head.win[k][l]}))
                                * PROD_W'(coef_reg[k][l]);
            end
        end
    end

    // Sums wrap modulo 2^17; the exact total always fits that range.
    always_comb begin
        for (int k = 0; k < MASK_SIZE; k++) begin
            row_sum_next[k] = '0;
            for (int l = 0; l < MASK_SIZE; l++) begin
                row_sum_next[k] = row_sum_next[k] + FV_W'(prod_reg[k][l]);
            end
        end
        total_next = '0;
        for (int k = 0; k < MASK_SIZE; k++) begin
            total_next = total_next + row_sum_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        coef_reg <= coef_next;
        if (adv) begin
            prod_reg     <= prod_next;
            b1_meta_reg  <= head.meta;
            row_sum_reg  <= row_sum_next;
            b2_meta_reg  <= b1_meta_reg;
            fv_reg       <= total_next;
            out_meta_reg <= b2_meta_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b1_valid_reg <= 1'b0;
            b2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else if (adv) begin
            b1_valid_reg <= pop;
            b2_valid_reg <= b1_valid_reg;
            m_valid_reg  <= b2_valid_reg;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_filtered_value = fv_reg;
    assign m_centre_row     = out_meta_reg.centre_row;
    assign m_centre_col     = out_meta_reg.centre_col;
    assign m_frame_last     = out_meta_reg.frame_last;

endmodule

/* sv/laws_texture_convolution_5x5.sv */
// ============================================================================
// Laws texture convolution, 5x5
// Streaming 2D convolution of a grey image with one separable Laws mask.
// ============================================================================
// Usage:
//   Pixels enter in raster order on the s_ channel (s_valid/s_ready, one
//   8-bit pixel per request). For every pixel that closes a 5x5 window fully
//   inside the image, one result leaves on the m_ channel: the signed sum,
//   the window centre row and column, and frame_last on the frame's final
//   result. Border pixels produce no result.
//   Registers are written through cfg_wr_en/cfg_index/cfg_wdata while the
//   block is idle: row and column vector select, image width and height.
//   Throughput is one pixel per cycle unless m_ready stalls the output, set
//   by the line buffer memory, which reads and writes one column of four
//   stored rows each cycle.
//   Reset clears counters, queue and valids and restores register defaults
//   (L5 x L5, 1024 x 1024). The line buffers are not cleared; the first four
//   rows of a frame fill them before any window reads them.
//   When m_ready is low the output register holds its request, the back end
//   stops, windows collect in a four-entry queue, and s_ready falls once the
//   queue together with the front stages could fill it.
// ============================================================================
`timescale 1ns / 1ps

module laws_texture_convolution_5x5 import laws5_pkg::*; #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [PIX_W-1:0]       s_pixel,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic signed [FV_W-1:0] m_filtered_value,
    output logic [POS_W-1:0]       m_centre_row,
    output logic [POS_W-1:0]       m_centre_col,
    output logic                   m_frame_last,
    input  logic                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [DIM_W-1:0]       cfg_wdata
);

    cfg_t    cfg_reg;
    logic    push, pop;
    item_t   push_item, head;
    q_stat_t q_stat;

    // Configuration registers. Selector codes above W5 are kept as written
    // and saturate where the taps are looked up; sizes are clamped in the
    // front end.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.row_sel      <= SEL_L5;
            cfg_reg.col_sel      <= SEL_L5;
            cfg_reg.image_width  <= DIM_RESET;
            cfg_reg.image_height <= DIM_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_ROW_SEL: cfg_reg.row_sel      <= cfg_wdata[SEL_W-1:0];
                CFG_COL_SEL: cfg_reg.col_sel      <= cfg_wdata[SEL_W-1:0];
                CFG_WIDTH:   cfg_reg.image_width  <= cfg_wdata;
                CFG_HEIGHT:  cfg_reg.image_height <= cfg_wdata;
            endcase
        end
    end

    // Front end: counts the raster position, keeps the line buffers and the
    // window, and hands every complete window to the queue.
    laws5_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_pixel   (s_pixel),
        .cfg       (cfg_reg),
        .q_stat    (q_stat),
        .push      (push),
        .push_item (push_item)
    );

    // The queue lets the front keep taking pixels while the back end waits
    // on the receiver.
    laws5_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .q_stat    (q_stat)
    );

    // Back end: multiply, sum by rows, total, register the request.
    laws5_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg              (cfg_reg),
        .q_stat           (q_stat),
        .head             (head),
        .pop              (pop),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_filtered_value (m_filtered_value),
        .m_centre_row     (m_centre_row),
        .m_centre_col     (m_centre_col),
        .m_frame_last     (m_frame_last)
    );

endmodule

/* sv/laws5_checker.sv */
// ============================================================================
// Laws 5x5 port checker
// Watches the top-level ports for result hold, reset and causality.
// ============================================================================
`timescale 1ns / 1ps
`include "laws_texture_convolution_5x5_macros.svh"

module laws5_checker import laws5_pkg::*; (
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_valid,
    input logic                   s_ready,
    input logic                   m_valid,
    input logic                   m_ready,
    input logic signed [FV_W-1:0] m_filtered_value,
    input logic [POS_W-1:0]       m_centre_row,
    input logic [POS_W-1:0]       m_centre_col,
    input logic                   m_frame_last
);

    logic seen_input_reg;

    // Set once any pixel has been taken since reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_input_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            seen_input_reg <= 1'b1;
        end
    end

    `L5_ASSERT_NEXT(a_result_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_filtered_value) && $stable(m_centre_row) && $stable(m_centre_col) && $stable(m_frame_last), "result changed while stalled")
    `L5_ASSERT_NEXT(a_reset_clears, aclk, 1'b1, !aresetn, !m_valid, "result valid after reset")
    `L5_ASSERT_SAME(a_no_early_result, aclk, aresetn, m_valid, seen_input_reg, "result before any pixel")

endmodule

bind laws_texture_convolution_5x5 laws5_checker u_laws5_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_valid          (s_valid),
    .s_ready          (s_ready),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_filtered_value (m_filtered_value),
    .m_centre_row     (m_centre_row),
    .m_centre_col     (m_centre_col),
    .m_frame_last     (m_frame_last)
);
